// File: design/kat_pkg.sv
`default_nettype none

package kat_pkg;

    // Array size of the systolic band and the sequence index width
    localparam int PE_COUNT       = 64;
    localparam int SEQ_INDEX_BITS = 16;

    // Field widths fixed by the interface
    localparam int LEN_W   = 16;
    localparam int POS_W   = 7;
    localparam int ARROW_W = 2;
    localparam int ROWS_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Derived sizes
    localparam int IDX_W     = (SEQ_INDEX_BITS < LEN_W) ? SEQ_INDEX_BITS : LEN_W;
    localparam int BAND_BITS = (2 * PE_COUNT > 128) ? 128 : 2 * PE_COUNT;
    localparam int NPOS_W    = POS_W + 2;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Word widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    typedef enum logic [ARROW_W-1:0] {
        ARW_ERR  = 2'd0,
        ARW_UP   = 2'd1,
        ARW_LEFT = 2'd2,
        ARW_DIAG = 2'd3
    } arrow_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH_A       = 3'd0,
        CFG_LENGTH_B       = 3'd1,
        CFG_START_VERTICAL = 3'd2,
        CFG_START_BIT_POS  = 3'd3,
        CFG_START_ARROW    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [LEN_W-1:0]   length_a;
        logic [LEN_W-1:0]   length_b;
        logic               start_vertical;
        logic [POS_W-1:0]   start_bit_pos;
        arrow_t             start_arrow;
    } cfg_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic   is_start;
        arrow_t arrow;
    } op_t;

    typedef struct packed {
        logic               column_valid;
        logic               gap_a;
        logic               gap_b;
        logic [LEN_W-1:0]   index_a;
        logic [LEN_W-1:0]   index_b;
        logic [ROWS_W-1:0]  fetch_rows_back;
        logic [POS_W-1:0]   fetch_bit_pos;
        logic               done_res;
        logic               band_error;
    } res_t;

endpackage

`default_nettype wire

// File: design/kat_front.sv
`default_nettype none

module kat_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_kind,
    input  wire logic [1:0]    in_arrow,
    input  wire kat_pkg::arrow_t start_arrow,
    output logic               op_valid,
    input  wire logic          op_ready,
    output kat_pkg::op_t       op
);
    import kat_pkg::*;

    logic valid_reg;
    logic valid_next;
    op_t  op_reg;
    op_t  op_next;

    assign in_ready = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    // Classify: a start word takes its arrow from the configured first row
    always_comb begin
        valid_next = valid_reg;
        op_next    = op_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready) begin
            op_next.is_start = !in_kind;
            op_next.arrow    = in_kind ? arrow_t'(in_arrow) : start_arrow;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        op_reg <= op_next;
    end

endmodule

`default_nettype wire

// File: design/kat_queue.sv
`default_nettype none

module kat_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire kat_pkg::op_t push_op,
    output logic              push_ready,
    input  wire logic         pop,
    output logic              head_valid,
    output kat_pkg::op_t      head_op
);
    import kat_pkg::*;

    op_t               mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = mem[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: design/kat_back.sv
`default_nettype none

module kat_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire kat_pkg::cfg_t cfg,
    input  wire logic          op_valid,
    input  wire kat_pkg::op_t  op,
    output logic               op_pop,
    output logic               res_valid,
    input  wire logic          res_ready,
    output kat_pkg::res_t      res
);
    import kat_pkg::*;

    logic [IDX_W-1:0] rem_a_reg, rem_a_next;
    logic [IDX_W-1:0] rem_b_reg, rem_b_next;
    logic             vert_reg, vert_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             fin_reg, fin_next;
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg, res_next;

    assign op_pop    = op_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb begin
        logic [IDX_W-1:0]  ra;
        logic [IDX_W-1:0]  rb;
        logic              vt;
        logic [POS_W-1:0]  ps;
        logic              fn;
        arrow_t            a;
        logic [NPOS_W-1:0] shift;
        logic [NPOS_W-1:0] npos;
        logic              take_a;
        logic              take_b;

        ra     = rem_a_reg;
        rb     = rem_b_reg;
        vt     = vert_reg;
        ps     = pos_reg;
        fn     = fin_reg;
        a      = op.arrow;
        shift  = '0;
        npos   = '0;
        take_a = 1'b0;
        take_b = 1'b0;

        rem_a_next     = rem_a_reg;
        rem_b_next     = rem_b_reg;
        vert_next      = vert_reg;
        pos_next       = pos_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;

        if (res_ready) begin
            out_valid_next = 1'b0;
        end

        if (op_pop) begin
            // A start reloads the walk from the configured end of both sequences
            if (op.is_start) begin
                ra = cfg.length_a[IDX_W-1:0];
                rb = cfg.length_b[IDX_W-1:0];
                vt = cfg.start_vertical;
                ps = cfg.start_bit_pos;
                fn = 1'b0;
            end

            res_next       = '0;
            out_valid_next = 1'b1;

            if (fn || (ra == '0 && rb == '0)) begin
                fn = 1'b1;
                res_next.done_res = 1'b1;
            end else begin
                // Force the move once a sequence runs dry
                if (ra == '0) begin
                    a = ARW_LEFT;
                end else if (rb == '0) begin
                    a = ARW_UP;
                end

                take_a = (a != ARW_LEFT);
                take_b = (a != ARW_UP);
                if (take_a) begin
                    ra = ra - 1'b1;
                    res_next.index_a = LEN_W'(ra);
                end
                if (take_b) begin
                    rb = rb - 1'b1;
                    res_next.index_b = LEN_W'(rb);
                end
                res_next.column_valid = 1'b1;
                res_next.gap_a        = !take_a;
                res_next.gap_b        = !take_b;

                if (ra == '0 && rb == '0) begin
                    fn = 1'b1;
                    res_next.done_res = 1'b1;
                end else begin
                    case (a)
                        ARW_DIAG: begin
                            res_next.fetch_rows_back = ROWS_W'(2);
                        end
                        ARW_UP: begin
                            res_next.fetch_rows_back = ROWS_W'(1);
                            shift = vt ? '0 : NPOS_W'(-2);
                            vt    = !vt;
                        end
                        ARW_LEFT: begin
                            res_next.fetch_rows_back = ROWS_W'(1);
                            shift = vt ? NPOS_W'(2) : '0;
                            vt    = !vt;
                        end
                        default: begin
                            res_next.fetch_rows_back = '0;
                        end
                    endcase

                    // Hold the position when it would leave the band
                    npos = NPOS_W'(ps) + shift;
                    if (npos[NPOS_W-1] || (npos >= NPOS_W'(BAND_BITS))) begin
                        res_next.band_error = 1'b1;
                    end else begin
                        ps = npos[POS_W-1:0];
                    end
                    res_next.fetch_bit_pos = ps;
                end
            end

            rem_a_next = ra;
            rem_b_next = rb;
            vert_next  = vt;
            pos_next   = ps;
            fin_next   = fn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_a_reg     <= '0;
            rem_b_reg     <= '0;
            vert_reg      <= 1'b0;
            pos_reg       <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rem_a_reg     <= rem_a_next;
            rem_b_reg     <= rem_b_next;
            vert_reg      <= vert_next;
            pos_reg       <= pos_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// File: design/kband_alignment_traceback.sv
// Path: a word accepted on s_ passes the front register, a queue entry and the back output
// register before it shows on m_. Throughput: one word per cycle while m_tready does
// not stall, set by the back step unit, which decodes one arrow per cycle; a stalled m_tready
// backs up four words (front register, two queue entries, output register), then s_tready drops.
// Reset (aresetn low at a clock edge): clears the configuration registers, the walk
// state (counts as finished) and all valid flags; no clearing pass follows.
`default_nettype none

module kband_alignment_traceback (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [kat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kat_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [kat_pkg::S_TDATA_W-1:0]     s_tdata,  // [1:0] arrow
    input  wire logic                              s_tuser,  // [0] kind
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] column_valid, [1] gap_a, [2] gap_b, [18:3] index_a, [34:19] index_b,
    // [36:35] fetch_rows_back, [43:37] fetch_bit_pos, [44] band_error
    output logic [kat_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                   m_tlast   // done_res
);
    import kat_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic front_valid;
    logic queue_ready;
    op_t  front_op;
    logic head_valid;
    op_t  head_op;
    logic head_pop;
    res_t res;

    // Configuration registers: written by the user only while idle; the block does not check
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_LENGTH_A:       cfg_next.length_a       = cfg_wr_data[LEN_W-1:0];
                CFG_LENGTH_B:       cfg_next.length_b       = cfg_wr_data[LEN_W-1:0];
                CFG_START_VERTICAL: cfg_next.start_vertical = cfg_wr_data[0];
                CFG_START_BIT_POS:  cfg_next.start_bit_pos  = cfg_wr_data[POS_W-1:0];
                CFG_START_ARROW:    cfg_next.start_arrow    = arrow_t'(cfg_wr_data[ARROW_W-1:0]);
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify words, resolving the arrow of a start word
    kat_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_arrow    (s_tdata[ARROW_W-1:0]),
        .start_arrow (cfg_reg.start_arrow),
        .op_valid    (front_valid),
        .op_ready    (queue_ready),
        .op          (front_op)
    );

    // Short queue: lets the front keep taking words while the back waits on m_tready
    kat_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_valid),
        .push_op    (front_op),
        .push_ready (queue_ready),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // Back: advance the traceback walk and hold one result in its output register
    kat_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .op_valid  (head_valid),
        .op        (head_op),
        .op_pop    (head_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result word, first field in the lowest bits
    assign m_tdata = {3'b000,
                      res.band_error,
                      res.fetch_bit_pos,
                      res.fetch_rows_back,
                      res.index_b,
                      res.index_a,
                      res.gap_b,
                      res.gap_a,
                      res.column_valid};
    assign m_tlast = res.done_res;

endmodule

`default_nettype wire

// File: tb/kband_alignment_traceback_checker.sv
module kband_alignment_traceback_checker
    import kat_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [1:0] arrow
    input  wire logic                  s_tuser,   // [0] kind
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,   // column fields, see below
    input  wire logic                  m_tlast,   // done_res
    output int                         mismatch_count,
    output int                         pending_count,
    output int                         column_count,
    output int                         finish_count,
    output int                         band_error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the configuration registers
    logic [LEN_W-1:0] cfg_len_a;
    logic [LEN_W-1:0] cfg_len_b;
    logic             cfg_vertical;
    logic [POS_W-1:0] cfg_bit_pos;
    arrow_t           cfg_arrow;

    // Walk state of the traceback
    logic [IDX_W-1:0] rem_a;
    logic [IDX_W-1:0] rem_b;
    logic             row_vertical;
    logic [POS_W-1:0] bit_pos;
    logic             walk_done;

    res_t expected_columns [$];
    res_t want;
    res_t got;

    // One traceback step: emit the aligned column and the next fetch address.
    function automatic res_t walk_back(input logic kind, input arrow_t fetched);
        res_t   r;
        arrow_t mv;
        int     shift;
        int     npos;
        r     = '0;
        shift = 0;
        if (!kind) begin
            rem_a        = cfg_len_a[IDX_W-1:0];
            rem_b        = cfg_len_b[IDX_W-1:0];
            row_vertical = cfg_vertical;
            bit_pos      = cfg_bit_pos;
            walk_done    = 1'b0;
            mv           = cfg_arrow;
        end else begin
            mv = fetched;
        end
        if (walk_done || (rem_a == '0 && rem_b == '0)) begin
            walk_done  = 1'b1;
            r.done_res = 1'b1;
            return r;
        end
        // an exhausted sequence forces the move
        if (rem_a == '0)
            mv = ARW_LEFT;
        else if (rem_b == '0)
            mv = ARW_UP;
        case (mv)
            ARW_UP: begin
                rem_a     = rem_a - 1'b1;
                r.index_a = rem_a;
                r.gap_b   = 1'b1;
            end
            ARW_LEFT: begin
                rem_b     = rem_b - 1'b1;
                r.index_b = rem_b;
                r.gap_a   = 1'b1;
            end
            default: begin
                rem_a     = rem_a - 1'b1;
                rem_b     = rem_b - 1'b1;
                r.index_a = rem_a;
                r.index_b = rem_b;
            end
        endcase
        r.column_valid = 1'b1;
        if (rem_a == '0 && rem_b == '0) begin
            walk_done  = 1'b1;
            r.done_res = 1'b1;
            return r;
        end
        case (mv)
            ARW_DIAG: r.fetch_rows_back = 2'd2;
            ARW_UP: begin
                r.fetch_rows_back = 2'd1;
                shift             = row_vertical ? 0 : -2;
                row_vertical      = ~row_vertical;
            end
            ARW_LEFT: begin
                r.fetch_rows_back = 2'd1;
                shift             = row_vertical ? 2 : 0;
                row_vertical      = ~row_vertical;
            end
            default: r.fetch_rows_back = 2'd0;
        endcase
        npos = int'(bit_pos) + shift;
        if (npos < 0 || npos >= BAND_BITS)
            r.band_error = 1'b1;
        else
            bit_pos = POS_W'(npos);
        r.fetch_bit_pos = bit_pos;
        return r;
    endfunction

    function automatic int field_diff(input string field, input longint unsigned want_v,
                                      input longint unsigned got_v);
        if (want_v == got_v)
            return 0;
        $error("%s: expected %0d, got %0d", field, want_v, got_v);
        return 1;
    endfunction

    initial begin
        mismatch_count   = 0;
        pending_count    = 0;
        column_count     = 0;
        finish_count     = 0;
        band_error_count = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_len_a    = '0;
            cfg_len_b    = '0;
            cfg_vertical = 1'b0;
            cfg_bit_pos  = '0;
            cfg_arrow    = ARW_ERR;
            rem_a        = '0;
            rem_b        = '0;
            row_vertical = 1'b0;
            bit_pos      = '0;
            walk_done    = 1'b0;
            expected_columns.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_LENGTH_A:       cfg_len_a    = cfg_wr_data[LEN_W-1:0];
                    CFG_LENGTH_B:       cfg_len_b    = cfg_wr_data[LEN_W-1:0];
                    CFG_START_VERTICAL: cfg_vertical = cfg_wr_data[0];
                    CFG_START_BIT_POS:  cfg_bit_pos  = cfg_wr_data[POS_W-1:0];
                    CFG_START_ARROW:    cfg_arrow    = arrow_t'(cfg_wr_data[ARROW_W-1:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_columns.size() == 0) begin
                    $error("result word with nothing expected: tdata %h last %b",
                           m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_columns.pop_front();
                    got.column_valid    = m_tdata[0];
                    got.gap_a           = m_tdata[1];
                    got.gap_b           = m_tdata[2];
                    got.index_a         = m_tdata[18:3];
                    got.index_b         = m_tdata[34:19];
                    got.fetch_rows_back = m_tdata[36:35];
                    got.fetch_bit_pos   = m_tdata[43:37];
                    got.band_error      = m_tdata[44];
                    got.done_res        = m_tlast;
                    mismatch_count += field_diff("column_valid", want.column_valid,
                                                 got.column_valid)
                        + field_diff("gap_a", want.gap_a, got.gap_a)
                        + field_diff("gap_b", want.gap_b, got.gap_b)
                        + field_diff("index_a", want.index_a, got.index_a)
                        + field_diff("index_b", want.index_b, got.index_b)
                        + field_diff("fetch_rows_back", want.fetch_rows_back,
                                     got.fetch_rows_back)
                        + field_diff("fetch_bit_pos", want.fetch_bit_pos, got.fetch_bit_pos)
                        + field_diff("done_res", want.done_res, got.done_res)
                        + field_diff("band_error", want.band_error, got.band_error);
                    column_count     += got.column_valid;
                    finish_count     += got.done_res;
                    band_error_count += got.band_error;
                end
            end
            if (s_tvalid && s_tready)
                expected_columns.push_back(walk_back(s_tuser,
                                                     arrow_t'(s_tdata[ARROW_W-1:0])));
        end
        pending_count = expected_columns.size();
    end

endmodule

// File: tb/kband_alignment_traceback_test.sv
module kband_alignment_traceback_test;
    import kat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 700;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 60;    // cycles the sink refuses words under pressure
    localparam int SETTLE       = 4;     // settling wait beyond the pipeline depth

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // [1:0] arrow
    logic                  s_tuser;    // [0] kind
    logic                  m_tvalid;
    logic                  m_tready;
    // [0] column_valid, [1] gap_a, [2] gap_b, [18:3] index_a, [34:19] index_b,
    // [36:35] fetch_rows_back, [43:37] fetch_bit_pos, [44] band_error
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;    // done_res

    int mismatches;
    int pending;
    int columns;
    int finishes;
    int band_errors;

    int cycle_count;
    int words_sent;
    int walks;
    int burst_left;
    logic long_hold_req;
    logic long_hold_done;

    kband_alignment_traceback i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    kband_alignment_traceback_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .mismatch_count   (mismatches),
        .pending_count    (pending),
        .column_count     (columns),
        .finish_count     (finishes),
        .band_error_count (band_errors)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Hard stop: a hung handshake must not run forever.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Sink side: switch between stall patterns after a random run of cycles, one of them
    // never stalling. When the source asks for pressure, hold off so the pipeline
    // fills and backs up onto s_tready.
    initial begin : result_sink
        int mode;
        int mode_left;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        long_hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold_req && !long_hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one word; called and returning at a falling edge. Bursts of random
    // length are separated by random gaps, so idles land on every phase of a walk.
    task automatic send_word(input logic kind, input arrow_t arw);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-ARROW_W){1'b0}}, arw};
        do
            @(posedge aclk);
        while (!s_tready);
        burst_left--;
        words_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and wait until every expected word is back, plus the pipeline depth.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Write all five registers on consecutive cycles; only while the block is idle.
    task automatic load_setup(input logic [LEN_W-1:0] len_a, input logic [LEN_W-1:0] len_b,
                              input logic vert, input logic [POS_W-1:0] pos,
                              input arrow_t first_arrow);
        cfg_index_t            regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{CFG_LENGTH_A, CFG_LENGTH_B, CFG_START_VERTICAL, CFG_START_BIT_POS,
                 CFG_START_ARROW};
        vals = '{len_a, len_b, CFG_DATA_W'(vert), CFG_DATA_W'(pos), CFG_DATA_W'(first_arrow)};
        foreach (regs[i]) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= regs[i];
            cfg_wr_data <= vals[i];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        walks++;
    endtask

    function automatic arrow_t pick_arrow();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ARW_ERR;
        if (r <= 3)
            return ARW_UP;
        if (r <= 6)
            return ARW_LEFT;
        return ARW_DIAG;
    endfunction

    // Mostly short sequences so walks finish; now and then empty or huge ones.
    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 19))
            0:       return '1;
            1:       return '0;
            2:       return LEN_W'($urandom_range(13, 65535));
            default: return LEN_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_bit_pos();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return POS_W'(1);
            3:       return POS_W'(BAND_BITS - 2);
            default: return POS_W'($urandom_range(0, 127));
        endcase
    endfunction

    initial begin : stimulus
        logic [LEN_W-1:0] len_a;
        logic [LEN_W-1:0] len_b;
        int               steps;
        int               roll;
        logic             pressure_done;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        long_hold_req = 1'b0;
        words_sent    = 0;
        walks         = 0;
        burst_left    = 0;
        pressure_done = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Arrows before any start: the reset state reads as finished.
        send_word(1'b1, ARW_DIAG);
        send_word(1'b1, ARW_ERR);

        // Both sequences empty: done at once, and again on a stray arrow.
        drain();
        load_setup('0, '0, 1'b0, '0, ARW_DIAG);
        send_word(1'b0, ARW_ERR);
        send_word(1'b1, ARW_UP);

        // Left from the top of a vertical row leaves the band; then an error arrow
        // with both sides left, an up, and a diagonal that ends the walk.
        drain();
        load_setup(16'd3, 16'd3, 1'b1, '1, ARW_LEFT);
        send_word(1'b0, ARW_UP);
        send_word(1'b1, ARW_ERR);
        send_word(1'b1, ARW_UP);
        send_word(1'b1, ARW_DIAG);
        send_word(1'b1, ARW_LEFT);

        // Longest sequences: up from position zero in a horizontal row leaves the band.
        drain();
        load_setup('1, '1, 1'b0, '0, ARW_UP);
        send_word(1'b0, ARW_DIAG);
        send_word(1'b1, ARW_LEFT);
        send_word(1'b1, ARW_DIAG);
        send_word(1'b1, ARW_ERR);
        send_word(1'b1, ARW_UP);

        // Sequence A empty: every move is forced to left.
        drain();
        load_setup('0, 16'd3, 1'b1, POS_W'(BAND_BITS - 2), ARW_DIAG);
        send_word(1'b0, ARW_UP);
        send_word(1'b1, ARW_UP);
        send_word(1'b1, ARW_ERR);
        send_word(1'b1, ARW_DIAG);

        // Sequence B empty: every move is forced to up.
        drain();
        load_setup(16'd3, '0, 1'b0, POS_W'(1), ARW_LEFT);
        send_word(1'b0, ARW_LEFT);
        send_word(1'b1, ARW_LEFT);
        send_word(1'b1, ARW_DIAG);
        send_word(1'b1, ARW_ERR);

        // Random walks: a fresh setup, a start, then arrows until a little past the finish
        // or a cap of 40 steps. A few words restart the walk midway or carry a stray start.
        while (words_sent < ITEM_TARGET) begin
            drain();
            if (!pressure_done && words_sent >= 250) begin
                // Keep offering back-to-back while the sink holds off.
                load_setup(16'd40, 16'd40, 1'b1, POS_W'(BAND_BITS / 2), ARW_DIAG);
                long_hold_req = 1'b1;
                burst_left    = 1000;
                send_word(1'b0, pick_arrow());
                repeat (80) send_word(1'b1, pick_arrow());
                burst_left    = 0;
                pressure_done = 1'b1;
            end else begin
                len_a = pick_length();
                len_b = pick_length();
                load_setup(len_a, len_b, 1'($urandom_range(0, 1)), pick_bit_pos(),
                           arrow_t'($urandom_range(0, 3)));
                send_word(1'b0, arrow_t'($urandom_range(0, 3)));
                steps = int'(len_a) + int'(len_b);
                if (steps > 40)
                    steps = 40;
                steps += $urandom_range(0, 2);
                repeat (steps) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        send_word(1'b0, arrow_t'($urandom_range(0, 3)));
                    else
                        send_word(1'b1, pick_arrow());
                end
            end
        end

        // Wait out every expected word and the pipeline tail.
        drain();
        repeat (2 * SETTLE) @(negedge aclk);

        $display("tb: %0d words over %0d walks; %0d columns, %0d finishes, %0d band errors",
                 words_sent, walks, columns, finishes, band_errors);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
